// ===== hdl/ifmt_pkg.sv =====
// Shared types, constants and helper functions for the integer field formatter.
`timescale 1ns / 1ps
package ifmt_pkg;

   localparam int MAX_WIDTH_DEF = 48;
   localparam int W_BITS        = 6;
   localparam int P_BITS        = 6;
   localparam int CNT_BITS      = 7;

   localparam logic [2:0] KIND_SDEC  = 3'd0;
   localparam logic [2:0] KIND_UDEC  = 3'd1;
   localparam logic [2:0] KIND_HEXS  = 3'd2;
   localparam logic [2:0] KIND_HEX16 = 3'd3;
   localparam logic [2:0] KIND_HEX32 = 3'd4;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UPPER_A = 8'h41;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_LEAD_SP,
      OP_SCAN_SP,
      OP_SCAN_SKIP,
      OP_SUB,
      OP_ZERO_SKIP,
      OP_SIGN,
      OP_DIGIT,
      OP_TRAIL_SP,
      OP_HEX,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type op;
      logic   idle;
   } cmd_type;

   typedef struct packed {
      logic req_is_dec;
      logic req_is_hex;
      logic w_gt10;
      logic scan_done;
      logic w_gt_pwr;
      logic n_ge_pow;
      logic digit_print;
      logic sign_pending;
      logic pwr_zero;
      logic hex_last;
      logic cnt_lt_w;
      logic can_emit;
      logic out_free;
      logic hold_v;
   } status_type;

   function automatic logic [31:0] pow10(input logic [3:0] p);
      logic [31:0] r;
      unique case (p)
         4'd0:    r = 32'd1;
         4'd1:    r = 32'd10;
         4'd2:    r = 32'd100;
         4'd3:    r = 32'd1000;
         4'd4:    r = 32'd10000;
         4'd5:    r = 32'd100000;
         4'd6:    r = 32'd1000000;
         4'd7:    r = 32'd10000000;
         4'd8:    r = 32'd100000000;
         4'd9:    r = 32'd1000000000;
         default: r = 32'd1;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
      logic [7:0] r;
      if (nib > 4'd9) begin
         r = CH_UPPER_A + {4'd0, nib} - 8'd10;
      end else begin
         r = CH_ZERO + {4'd0, nib};
      end
      return r;
   endfunction

endpackage

// ===== hdl/ifmt_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps
interface ifmt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] value;
   logic [5:0]  field_width;
   logic [3:0]  precision;
   logic        plus_flag;
   logic        zero_flag;

   modport source (output valid, kind, value, field_width, precision, plus_flag,
                   zero_flag, input ready);
   modport sink (input valid, kind, value, field_width, precision, plus_flag,
                 zero_flag, output ready);
endinterface

interface ifmt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source (output valid, out_char, last, input ready);
   modport sink (input valid, out_char, last, output ready);
endinterface

// ===== hdl/ifmt_ctrl.sv =====
// Sequencing state machine for the integer field formatter.
`timescale 1ns / 1ps
module ifmt_ctrl import ifmt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type stat,
   output cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_LEAD  = 9'b000000010,
      S_SCAN  = 9'b000000100,
      S_DIV   = 9'b000001000,
      S_SIGN  = 9'b000010000,
      S_DIGIT = 9'b000100000,
      S_TRAIL = 9'b001000000,
      S_HEX   = 9'b010000000,
      S_FIN   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NOP;
      cmd.idle = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               if (stat.req_is_dec) begin
                  state_in = S_LEAD;
               end else if (stat.req_is_hex) begin
                  state_in = S_HEX;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_LEAD: begin
            if (stat.w_gt10) begin
               if (stat.can_emit) cmd.op = OP_LEAD_SP;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_DIV;
            end else if (stat.w_gt_pwr) begin
               if (stat.can_emit) cmd.op = OP_SCAN_SP;
            end else begin
               cmd.op = OP_SCAN_SKIP;
            end
         end
         S_DIV: begin
            if (stat.n_ge_pow) begin
               cmd.op = OP_SUB;
            end else if (stat.digit_print) begin
               state_in = stat.sign_pending ? S_SIGN : S_DIGIT;
            end else begin
               cmd.op = OP_ZERO_SKIP;
            end
         end
         S_SIGN: begin
            if (stat.can_emit) begin
               cmd.op   = OP_SIGN;
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (stat.can_emit) begin
               cmd.op   = OP_DIGIT;
               state_in = stat.pwr_zero ? S_TRAIL : S_DIV;
            end
         end
         S_TRAIL: begin
            if (stat.cnt_lt_w) begin
               if (stat.can_emit) cmd.op = OP_TRAIL_SP;
            end else begin
               state_in = S_FIN;
            end
         end
         S_HEX: begin
            if (stat.can_emit) begin
               cmd.op = OP_HEX;
               if (stat.hex_last) state_in = S_TRAIL;
            end
         end
         S_FIN: begin
            if (!stat.hold_v) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.op   = OP_FLUSH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/ifmt_dp.sv =====
// Datapath: working registers, digit extraction, character hold and output stage.
`timescale 1ns / 1ps
module ifmt_dp import ifmt_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [2:0]  kind,
   input  logic [31:0] value,
   input  logic [5:0]  field_width,
   input  logic [3:0]  precision,
   input  logic        plus_flag,
   input  logic        zero_flag,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [7:0]  rsp_char,
   output logic        rsp_last,
   output status_type  stat
);

   localparam logic [W_BITS-1:0] WMAX = W_BITS'(MAX_WIDTH);

   logic [31:0]         n_ff, n_in;
   logic [W_BITS-1:0]   w_ff, w_in;
   logic [P_BITS-1:0]   prec_ff, prec_in;
   logic [3:0]          pwr_ff, pwr_in;
   logic [3:0]          q_ff, q_in;
   logic [2:0]          idx_ff, idx_in;
   logic                neg_ff, neg_in, plus_ff, plus_in, started_ff, started_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [7:0]          hold_ff, hold_in;
   logic                hold_v_ff, hold_v_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_dec, req_neg, req_sign;
   logic [W_BITS-1:0]   wsat;
   logic [31:0]         pow, nib_word;
   logic [P_BITS-1:0]   pwr_ext, pwr_ext1;
   logic                emit;
   logic [7:0]          ch;

   assign req_dec  = (kind == KIND_SDEC) || (kind == KIND_UDEC);
   assign req_neg  = (kind == KIND_SDEC) && value[31];
   assign req_sign = req_neg || plus_flag;
   assign wsat     = (field_width > WMAX) ? WMAX : field_width;

   assign pow      = pow10(pwr_ff);
   assign pwr_ext  = {2'b00, pwr_ff};
   assign pwr_ext1 = pwr_ext + P_BITS'(1);
   assign nib_word = n_ff >> {idx_ff, 2'b00};

   always_comb begin
      stat.req_is_dec   = req_dec;
      stat.req_is_hex   = (kind == KIND_HEXS) || (kind == KIND_HEX16) ||
                          (kind == KIND_HEX32);
      stat.w_gt10       = w_ff > W_BITS'(10);
      stat.n_ge_pow     = n_ff >= pow;
      stat.pwr_zero     = (pwr_ff == 4'd0);
      stat.scan_done    = stat.pwr_zero || stat.n_ge_pow || (prec_ff > pwr_ext);
      stat.w_gt_pwr     = w_ff > pwr_ext;
      stat.sign_pending = neg_ff || plus_ff;
      stat.digit_print  = (q_ff != 4'd0) || started_ff || stat.pwr_zero ||
                          (prec_ff > (stat.sign_pending ? pwr_ext1 : pwr_ext));
      stat.hex_last     = (idx_ff == 3'd0);
      stat.cnt_lt_w     = cnt_ff < {1'b0, w_ff};
      stat.out_free     = !rsp_valid_ff || rsp_ready;
      stat.hold_v       = hold_v_ff;
      stat.can_emit     = !hold_v_ff || stat.out_free;
   end

   always_comb begin
      emit = 1'b0;
      ch   = CH_SPACE;
      unique case (cmd.op)
         OP_LEAD_SP, OP_SCAN_SP, OP_TRAIL_SP: emit = 1'b1;
         OP_SIGN: begin
            emit = 1'b1;
            ch   = neg_ff ? CH_MINUS : CH_PLUS;
         end
         OP_DIGIT: begin
            emit = 1'b1;
            ch   = CH_ZERO + {4'd0, q_ff};
         end
         OP_HEX: begin
            emit = 1'b1;
            ch   = hex_ascii(nib_word[3:0]);
         end
         default: emit = 1'b0;
      endcase
   end

   always_comb begin
      n_in       = n_ff;
      w_in       = w_ff;
      prec_in    = prec_ff;
      pwr_in     = pwr_ff;
      q_in       = q_ff;
      idx_in     = idx_ff;
      neg_in     = neg_ff;
      plus_in    = plus_ff;
      started_in = started_ff;
      cnt_in     = cnt_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            if (req_dec) begin
               n_in = req_neg ? (32'd0 - value) : value;
            end else if (kind == KIND_HEX32) begin
               n_in = value;
            end else begin
               n_in = {16'd0, value[15:0]};
            end
            w_in = (req_dec && req_sign && (wsat != '0)) ? wsat - W_BITS'(1) : wsat;
            prec_in = (zero_flag && (wsat > {2'b00, precision})) ? wsat
                                                                  : {2'b00, precision};
            if (kind == KIND_HEX32) begin
               idx_in = 3'd7;
            end else if (kind == KIND_HEX16 || value[15:8] != 8'd0) begin
               idx_in = 3'd3;
            end else begin
               idx_in = 3'd1;
            end
            pwr_in     = 4'd9;
            q_in       = 4'd0;
            neg_in     = req_neg;
            plus_in    = plus_flag;
            started_in = 1'b0;
            cnt_in     = '0;
         end
         OP_LEAD_SP:                pwr_in = pwr_ff;
         OP_SCAN_SP, OP_SCAN_SKIP:  pwr_in = pwr_ff - 4'd1;
         OP_SUB: begin
            n_in = n_ff - pow;
            q_in = q_ff + 4'd1;
         end
         OP_ZERO_SKIP: begin
            pwr_in = pwr_ff - 4'd1;
            q_in   = 4'd0;
         end
         OP_SIGN: begin
            neg_in  = 1'b0;
            plus_in = 1'b0;
         end
         OP_DIGIT: begin
            started_in = 1'b1;
            q_in       = 4'd0;
            if (!stat.pwr_zero) pwr_in = pwr_ff - 4'd1;
         end
         OP_HEX:    idx_in = idx_ff - 3'd1;
         default:   n_in = n_ff;
      endcase
      if (cmd.op == OP_LEAD_SP) w_in = w_ff - W_BITS'(1);
      if (emit) cnt_in = cnt_ff + CNT_BITS'(1);
   end

   // Hold one character back so the final one can carry the last marker.
   always_comb begin
      hold_in      = hold_ff;
      hold_v_in    = hold_v_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         hold_in   = ch;
         hold_v_in = 1'b1;
         if (hold_v_ff) begin
            rsp_char_in  = hold_ff;
            rsp_last_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end
      end else if (cmd.op == OP_FLUSH) begin
         hold_v_in    = 1'b0;
         rsp_char_in  = hold_ff;
         rsp_last_in  = 1'b1;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      w_ff        <= w_in;
      prec_ff     <= prec_in;
      pwr_ff      <= pwr_in;
      q_ff        <= q_in;
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      plus_ff     <= plus_in;
      started_ff  <= started_in;
      cnt_ff      <= cnt_in;
      hold_ff     <= hold_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== hdl/integer_field_formatter.sv =====
// Top level of the integer field formatter: controller, datapath and checks.
`timescale 1ns / 1ps
// Usage:
//   req_ch carries one format request (kind, value, field_width, precision,
//   plus_flag, zero_flag). A transfer happens when valid and ready are high
//   at a clock edge; ready is high only while the block is idle.
//   rsp_ch returns the formatted field one ASCII character per transfer,
//   most significant first, with last set on the final character.
//   Undefined kinds (five to seven) are taken and produce no characters.
// Sequencing:
//   Decimal digits come from repeated subtraction of the current power of
//   ten; lead spaces, scan steps, skipped leading zero positions, the
//   sign and hex digits each come from a single sequencer command. Each
//   character passes through a hold register and then the output
//   register, so one character is held back until the next one is
//   produced or the field is flushed with last set.
// Reset and stalls:
//   Synchronous reset returns the controller to idle and empties the
//   character hold and the output register. When rsp_ch stalls, the
//   sequencer holds at its next character-producing step; nothing is lost.
module integer_field_formatter import ifmt_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   ifmt_req_if.sink        req_ch,
   ifmt_rsp_if.source      rsp_ch
);

   cmd_type    cmd;
   status_type stat;

   // Sequence the layout: lead spaces, scan, sign, digits or hex digits, trailing spaces.
   ifmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the working number and drive characters into the output register.
   ifmt_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .kind        (req_ch.kind),
      .value       (req_ch.value),
      .field_width (req_ch.field_width),
      .precision   (req_ch.precision),
      .plus_flag   (req_ch.plus_flag),
      .zero_flag   (req_ch.zero_flag),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_char    (rsp_ch.out_char),
      .rsp_last    (rsp_ch.last),
      .stat        (stat)
   );

   // Accept a request only while idle.
   assign req_ch.ready = cmd.idle;

   // A character must never be produced into a full hold/output pair.
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LEAD_SP || cmd.op == OP_SCAN_SP || cmd.op == OP_SIGN ||
       cmd.op == OP_DIGIT || cmd.op == OP_TRAIL_SP || cmd.op == OP_HEX)
      |-> stat.can_emit)
      else $error("character produced without room");

   // Flush only moves a held character into a free output register.
   a_flush_ok: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FLUSH) |-> (stat.hold_v && stat.out_free))
      else $error("flush without held character or output room");

   // Idle means the previous field has been fully handed to the output.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !stat.hold_v)
      else $error("idle with a character still held");

   // A flush always ends the field with a last-marked character.
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FLUSH) |=> (rsp_ch.valid && rsp_ch.last))
      else $error("flush did not present the last character");

endmodule

// ===== tb/ifmt_tb_pkg.sv =====
// Testbench-side request record for the integer field formatter.
`timescale 1ns / 1ps
package ifmt_tb_pkg;
   import ifmt_pkg::*;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] value;
      logic [5:0]  field_width;
      logic [3:0]  precision;
      logic        plus_flag;
      logic        zero_flag;
   } fmt_req_type;
endpackage

// ===== tb/tb.sv =====
// Self-checking testbench for the integer field formatter.
`timescale 1ns / 1ps
module tb import ifmt_pkg::*, ifmt_tb_pkg::*;;

   localparam int LIMIT_CYCLES = 900000;
   localparam int N_RANDOM     = 300;

   logic clock;
   logic reset;

   ifmt_req_if req_ch();
   ifmt_rsp_if rsp_ch();

   integer_field_formatter u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Characters still owed by the block, oldest first; last flag in bit 8.
   logic [8:0] char_queue[$];
   int         n_mismatch;
   int         n_chars;
   int         n_fields;
   int         n_sent;
   int         cycle_count;
   bit         stim_done;
   bit         long_hold;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Append the expected characters of one request to char_queue.
   function automatic void format_field(input fmt_req_type r);
      logic [7:0]  chars[$];
      logic [31:0] mag;
      logic [31:0] pw;
      logic [31:0] q;
      int          w;
      int          prec;
      int          p;
      int          nd;
      bit          neg;
      bit          plus;
      bit          started;
      w = (r.field_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : r.field_width;
      prec = r.precision;
      mag = r.value;
      neg = 0;
      plus = r.plus_flag;
      started = 0;
      if (r.kind == KIND_SDEC || r.kind == KIND_UDEC) begin
         if (r.zero_flag && w > prec) prec = w;
         if (r.kind == KIND_SDEC && r.value[31]) begin
            neg = 1;
            mag = -r.value;
         end
         if ((neg || plus) && w > 0) w--;
         while (w > 10) begin
            chars.push_back(CH_SPACE);
            w--;
         end
         // scan down from 10^9 for the first significant power
         for (p = 9; p > 0; p--) begin
            pw = 1;
            repeat (p) pw = pw * 10;
            if (mag >= pw || prec > p) break;
            if (w > p) chars.push_back(CH_SPACE);
         end
         for (; p >= 0; p--) begin
            pw = 1;
            repeat (p) pw = pw * 10;
            q = mag / pw;
            mag = mag - q * pw;
            if (p == 0) started = 1;
            if (prec > ((neg || plus) ? p + 1 : p)) started = 1;
            if (q != 0 || started) begin
               if (neg) begin
                  chars.push_back(CH_MINUS);
                  neg = 0;
                  plus = 0;
               end else if (plus) begin
                  chars.push_back(CH_PLUS);
                  plus = 0;
               end
               chars.push_back(CH_ZERO + q[7:0]);
               started = 1;
            end
         end
      end else if (r.kind == KIND_HEXS || r.kind == KIND_HEX16
                   || r.kind == KIND_HEX32) begin
         if (r.kind == KIND_HEX32) nd = 8;
         else if (r.kind == KIND_HEX16 || r.value[15:8] != 0) nd = 4;
         else nd = 2;
         for (p = nd - 1; p >= 0; p--) begin
            q = (r.value >> (4 * p)) & 32'hF;
            chars.push_back(q > 9 ? CH_UPPER_A + q[7:0] - 8'd10 : CH_ZERO + q[7:0]);
         end
      end else begin
         return;  // undefined kinds give nothing
      end
      while (chars.size() < w) chars.push_back(CH_SPACE);
      foreach (chars[i]) char_queue.push_back({i == chars.size() - 1, chars[i]});
   endfunction

   // Directed rows: literal expectation where obvious, empty string = predictor.
   typedef struct {
      fmt_req_type r;
      string       lit;
   } dir_row_type;

   dir_row_type dir_rows[] = '{
      '{'{KIND_SDEC, 32'd0, 6'd0, 4'd0, 1'b0, 1'b0}, "0"},
      '{'{KIND_SDEC, 32'd0, 6'd0, 4'd0, 1'b1, 1'b0}, "+0"},
      '{'{KIND_SDEC, 32'h8000_0000, 6'd0, 4'd0, 1'b0, 1'b0}, "-2147483648"},
      '{'{KIND_SDEC, 32'h7FFF_FFFF, 6'd0, 4'd0, 1'b0, 1'b0}, "2147483647"},
      '{'{KIND_UDEC, 32'hFFFF_FFFF, 6'd0, 4'd0, 1'b0, 1'b0}, "4294967295"},
      '{'{KIND_UDEC, 32'hFFFF_FFFF, 6'd0, 4'd0, 1'b1, 1'b0}, "+4294967295"},
      '{'{KIND_SDEC, 32'hFFFF_FFFF, 6'd0, 4'd0, 1'b0, 1'b0}, "-1"},
      '{'{KIND_HEX32, 32'hDEAD_BEEF, 6'd0, 4'd0, 1'b0, 1'b0}, "DEADBEEF"},
      '{'{KIND_HEX16, 32'h1234_00AF, 6'd0, 4'd0, 1'b0, 1'b0}, "00AF"},
      '{'{KIND_HEXS, 32'h0000_007F, 6'd0, 4'd0, 1'b0, 1'b0}, "7F"},
      '{'{KIND_HEXS, 32'h0000_0100, 6'd0, 4'd0, 1'b0, 1'b0}, "0100"},
      '{'{KIND_HEX32, 32'h0, 6'd10, 4'd9, 1'b1, 1'b1}, "00000000  "},
      '{'{3'd5, 32'd7, 6'd4, 4'd0, 1'b0, 1'b0}, ""},
      '{'{3'd7, 32'hFFFF_FFFF, 6'd63, 4'd15, 1'b1, 1'b1}, ""},
      '{'{KIND_SDEC, 32'd42, 6'd63, 4'd0, 1'b0, 1'b0}, ""},
      '{'{KIND_SDEC, 32'hFFFF_FFD6, 6'd48, 4'd3, 1'b1, 1'b1}, ""},
      '{'{KIND_UDEC, 32'd5, 6'd8, 4'd15, 1'b0, 1'b0}, ""},
      '{'{KIND_SDEC, 32'd5, 6'd6, 4'd0, 1'b1, 1'b1}, ""},
      '{'{KIND_SDEC, 32'hFFFF_FFFB, 6'd12, 4'd4, 1'b0, 1'b0}, ""},
      '{'{KIND_UDEC, 32'd123, 6'd2, 4'd9, 1'b1, 1'b0}, ""},
      '{'{KIND_HEX32, 32'hFFFF_FFFF, 6'd63, 4'd0, 1'b0, 1'b0}, ""},
      '{'{KIND_HEXS, 32'h0000_FF00, 6'd5, 4'd0, 1'b1, 1'b1}, ""}
   };

   // Hand one request to the block; predict at the transfer edge.
   // Valid stays high into a back-to-back request and drops only for a gap.
   task automatic send_req(input fmt_req_type r, input string lit);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                        : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;  // keep some back-to-back runs
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= r.kind;
      req_ch.value       <= r.value;
      req_ch.field_width <= r.field_width;
      req_ch.precision   <= r.precision;
      req_ch.plus_flag   <= r.plus_flag;
      req_ch.zero_flag   <= r.zero_flag;
      do @(posedge clock); while (!req_ch.ready);
      // transfer taken at this edge
      if (lit.len() != 0) begin
         for (int i = 0; i < lit.len(); i++)
            char_queue.push_back({i == lit.len() - 1, lit[i]});
      end else begin
         format_field(r);
      end
      n_sent++;
   endtask

   function automatic fmt_req_type rand_req();
      fmt_req_type r;
      r.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 4))
         0:       r.value = $urandom_range(0, 9);
         1:       r.value = $urandom_range(0, 99999);
         2:       r.value = -$urandom_range(1, 1000);
         default: r.value = $urandom;
      endcase
      // mostly narrow fields, occasionally wide to the saturation point
      r.field_width = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, 14));
      r.precision = 4'($urandom_range(0, 15));
      r.plus_flag = 1'($urandom_range(0, 1));
      r.zero_flag = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Stimulus.
   initial begin
      fmt_req_type r;
      reset = 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= '0;
      req_ch.value       <= '0;
      req_ch.field_width <= '0;
      req_ch.precision   <= '0;
      req_ch.plus_flag   <= 1'b0;
      req_ch.zero_flag   <= 1'b0;
      stim_done = 0;
      n_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) send_req(dir_rows[i].r, dir_rows[i].lit);
      for (int i = 0; i < N_RANDOM; i++) begin
         r = rand_req();
         send_req(r, "");
      end
      req_ch.valid <= 1'b0;
      stim_done = 1;
   end

   // Receiver: random stalls, plus one long hold-off mid-run.
   initial begin
      rsp_ch.ready <= 1'b0;
      long_hold = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!long_hold && n_sent == 60) begin
            long_hold = 1;
            rsp_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         if ($urandom_range(0, 1) == 0)
            rsp_ch.ready <= 1'b1;
         else if ($urandom_range(0, 15) == 0)
            rsp_ch.ready <= 1'b0;  // stays low until drawn high again
         else
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Check each character transfer against the oldest expectation.
   always @(posedge clock) begin
      logic [8:0] exp_c;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_chars++;
         if (rsp_ch.last) n_fields++;
         if (char_queue.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
               $display("unexpected char %h last %b", rsp_ch.out_char, rsp_ch.last);
         end else begin
            exp_c = char_queue.pop_front();
            if (exp_c[7:0] !== rsp_ch.out_char || exp_c[8] !== rsp_ch.last) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("mismatch: expected %h last %b, got %h last %b",
                           exp_c[7:0], exp_c[8], rsp_ch.out_char, rsp_ch.last);
            end
         end
      end
   end

   // End of run and watchdog.
   initial begin
      n_mismatch = 0;
      n_chars = 0;
      n_fields = 0;
      cycle_count = 0;
      fork
         begin
            wait (stim_done);
            while (char_queue.size() != 0) @(posedge clock);
            repeat (200) @(posedge clock);
         end
         begin
            while (cycle_count < LIMIT_CYCLES) begin
               @(posedge clock);
               cycle_count++;
            end
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
         end
      join_any
      $display("%0d requests sent, %0d fields and %0d characters checked",
               n_sent, n_fields, n_chars);
      if (n_mismatch == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", n_mismatch);
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/ifmt_pkg.sv
hdl/ifmt_if.sv
hdl/ifmt_ctrl.sv
hdl/ifmt_dp.sv
hdl/integer_field_formatter.sv
tb/ifmt_tb_pkg.sv
tb/tb.sv
